/* design/gfau_pkg.sv */
// Shared types, codes and the microprogram of the GF(2^8) arithmetic unit.
package gfau_pkg;

  localparam int FieldW = 8;
  localparam int UpcW   = 3;

  localparam logic [FieldW-1:0] PolyReset = 8'd27;
  localparam logic [FieldW-1:0] FieldOne  = 8'h01;
  localparam logic [FieldW-1:0] InvExp    = 8'd254;

  typedef logic [FieldW-1:0] elem_t;
  typedef logic [UpcW-1:0]   upc_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_POW = 2'd2,
    KIND_INV = 2'd3
  } kind_t;

  // Multiplier operand selects.
  typedef enum logic [1:0] {MX_RES, MX_SQ, MX_A} mul_x_t;
  typedef enum logic {MY_SQ, MY_B} mul_y_t;

  // Source of the next accumulated result.
  typedef enum logic [1:0] {RS_HOLD, RS_ONE, RS_XOR, RS_MUL} res_src_t;

  // Jump conditions.
  typedef enum logic [1:0] {JC_NEVER, JC_EXP_NZ, JC_EXP_MORE} jump_t;

  // Microprogram addresses.
  localparam upc_t UpcAdd     = 3'd0;
  localparam upc_t UpcMul     = 3'd1;
  localparam upc_t UpcPowInit = 3'd2;
  localparam upc_t UpcPowMul  = 3'd3;
  localparam upc_t UpcPowSq   = 3'd4;

  typedef struct packed {
    mul_x_t   mx;
    mul_y_t   my;
    res_src_t rs;
    logic     res_if_bit;  // multiply result only if exponent bit 0 is set
    logic     sq_wr;
    logic     exp_shift;
    jump_t    jc;
    upc_t     target;
    logic     done;        // finish the item when no jump is taken
  } cword_t;

  typedef struct packed {
    cword_t cw;
    logic   step_en;
  } seq_ctl_t;

  typedef struct packed {
    logic exp_nz;
    logic exp_more;
  } dp_status_t;

  function automatic cword_t ucode(upc_t pc);
    cword_t w;
    w = '0;
    w.mx = MX_A;
    w.my = MY_B;
    w.rs = RS_HOLD;
    w.jc = JC_NEVER;
    unique case (pc)
      UpcAdd: begin
        w.rs   = RS_XOR;
        w.done = 1'b1;
      end
      UpcMul: begin
        w.rs   = RS_MUL;
        w.done = 1'b1;
      end
      UpcPowInit: begin
        w.rs     = RS_ONE;
        w.jc     = JC_EXP_NZ;
        w.target = UpcPowMul;
        w.done   = 1'b1;
      end
      UpcPowMul: begin
        w.mx         = MX_RES;
        w.my         = MY_SQ;
        w.rs         = RS_MUL;
        w.res_if_bit = 1'b1;
      end
      UpcPowSq: begin
        w.mx        = MX_SQ;
        w.my        = MY_SQ;
        w.sq_wr     = 1'b1;
        w.exp_shift = 1'b1;
        w.jc        = JC_EXP_MORE;
        w.target    = UpcPowMul;
        w.done      = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic upc_t entry_of(kind_t k);
    upc_t e;
    e = UpcPowInit;
    unique case (k)
      KIND_ADD: e = UpcAdd;
      KIND_MUL: e = UpcMul;
      KIND_POW: e = UpcPowInit;
      KIND_INV: e = UpcPowInit;
      default:  e = UpcPowInit;
    endcase
    return e;
  endfunction

endpackage

/* design/gf256_arithmetic_unit.sv */
// Top level of the GF(2^8) arithmetic unit: handshakes, polynomial register, result register.
//
// This unit adds, multiplies, exponentiates and inverts elements of GF(2^8) under the
// reduction polynomial x^8 + P, where P is the byte held in the polynomial register
// (reset value 0x1B, written through the cfg channel, which is always ready). Each input
// item carries kind (0 add, 1 multiply, 2 power, 3 inverse) and two operands, and gives
// exactly one result item. A short microprogram drives a single shared field multiplier,
// one multiplication per cycle unless a step is held, and the block works on one item at
// a time: in_stall is high from the cycle after an item is accepted until its result is
// written into the output register. Add and multiply take one step after acceptance.
// Power takes a first step that yields 1 for exponent zero, and then for each bit of the
// exponent's bit length one conditional multiply step and one squaring step on the shared
// multiplier; inverse raises the operand to 254 in the same way, mapping zero to zero.
// The result sits in an output register, so a new item is taken while an earlier result
// still waits under out_stall; the sequencer only holds its final step when that register
// is still occupied. The polynomial is not checked for irreducibility, and it should be
// written only while the unit is idle.
module gf256_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import gfau_pkg::*;

  elem_t      poly;
  logic       busy;
  logic       fire;
  logic       start;
  logic       blocked;
  seq_ctl_t   ctl;
  dp_status_t status;
  elem_t      res_d;

  // The polynomial register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= PolyReset;
    end else if (cfg_valid && cfg_ready) begin
      poly <= cfg_data;
    end
  end

  // One item in flight; a waiting result does not block acceptance.
  assign in_stall = busy;
  assign start    = in_valid & ~in_stall;
  assign blocked  = out_valid & out_stall;

  gfau_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_kind (kind_t'(kind)),
    .blocked    (blocked),
    .status     (status),
    .ctl        (ctl),
    .busy       (busy),
    .fire       (fire)
  );

  gfau_dp u_dp (
    .clk       (clk),
    .load      (start),
    .load_kind (kind_t'(kind)),
    .load_a    (operand_a),
    .load_b    (operand_b),
    .poly      (poly),
    .ctl       (ctl),
    .status    (status),
    .res_d     (res_d)
  );

  // Output register: filled when the program finishes, emptied when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_d;
    end
  end

  // An accepted item keeps the sequencer busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("sequencer not busy after accepting an item");

  // A finishing program never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst) fire |-> !(out_valid && out_stall))
    else $error("result written while output register is occupied");

  // A finished item always shows up on the output in the next cycle.
  assert property (@(posedge clk) disable iff (rst) fire |=> out_valid)
    else $error("finished item missing from output");

  // Results only come from a running program.
  assert property (@(posedge clk) disable iff (rst) fire |-> busy)
    else $error("result produced while sequencer idle");

endmodule

/* design/gfau_mul.sv */
// Carry-less 8-bit multiplier with reduction by x^8 plus a programmable low byte.
module gfau_mul (
  input  gfau_pkg::elem_t x,
  input  gfau_pkg::elem_t y,
  input  gfau_pkg::elem_t poly,
  output gfau_pkg::elem_t prod
);
  import gfau_pkg::*;

  // Horner form, most significant bit of y first.
  always_comb begin
    elem_t acc;
    acc = '0;
    for (int i = FieldW - 1; i >= 0; i--) begin
      acc = acc[FieldW-1] ? ({acc[FieldW-2:0], 1'b0} ^ poly) : {acc[FieldW-2:0], 1'b0};
      if (y[i]) begin
        acc = acc ^ x;
      end
    end
    prod = acc;
  end

endmodule

/* design/gfau_seq.sv */
// Microprogram sequencer: step counter, control-word fetch and conditional jumps.
module gfau_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  gfau_pkg::kind_t        start_kind,
  input  logic                   blocked,
  input  gfau_pkg::dp_status_t   status,
  output gfau_pkg::seq_ctl_t     ctl,
  output logic                   busy,
  output logic                   fire
);
  import gfau_pkg::*;

  upc_t   pc;
  cword_t cw;
  logic   jump;
  logic   finish;

  always_comb begin
    cw = ucode(pc);
    unique case (cw.jc)
      JC_EXP_NZ:   jump = status.exp_nz;
      JC_EXP_MORE: jump = status.exp_more;
      default:     jump = 1'b0;
    endcase
    finish      = busy & cw.done & ~jump;
    fire        = finish & ~blocked;
    ctl.cw      = cw;
    ctl.step_en = busy & ~(finish & blocked);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= UpcAdd;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= entry_of(start_kind);
    end else if (ctl.step_en) begin
      if (jump) begin
        pc <= cw.target;
      end else if (cw.done) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

/* design/gfau_dp.sv */
// Datapath: operand, square, exponent and result registers around one field multiplier.
module gfau_dp (
  input  logic                 clk,
  input  logic                 load,
  input  gfau_pkg::kind_t      load_kind,
  input  gfau_pkg::elem_t      load_a,
  input  gfau_pkg::elem_t      load_b,
  input  gfau_pkg::elem_t      poly,
  input  gfau_pkg::seq_ctl_t   ctl,
  output gfau_pkg::dp_status_t status,
  output gfau_pkg::elem_t      res_d
);
  import gfau_pkg::*;

  elem_t a_op;
  elem_t b_op;
  elem_t sq;
  elem_t expo;
  elem_t res;
  elem_t mul_x;
  elem_t mul_y;
  elem_t prod;

  gfau_mul u_mul (
    .x    (mul_x),
    .y    (mul_y),
    .poly (poly),
    .prod (prod)
  );

  always_comb begin
    unique case (ctl.cw.mx)
      MX_RES:  mul_x = res;
      MX_SQ:   mul_x = sq;
      default: mul_x = a_op;
    endcase
    mul_y = (ctl.cw.my == MY_SQ) ? sq : b_op;

    unique case (ctl.cw.rs)
      RS_HOLD: res_d = res;
      RS_ONE:  res_d = FieldOne;
      RS_XOR:  res_d = a_op ^ b_op;
      RS_MUL:  res_d = (ctl.cw.res_if_bit && !expo[0]) ? res : prod;
      default: res_d = res;
    endcase

    status.exp_nz   = |expo;
    status.exp_more = |expo[FieldW-1:1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_op <= load_a;
      b_op <= load_b;
      sq   <= load_a;
      expo <= (load_kind == KIND_INV) ? InvExp : load_b;
    end else if (ctl.step_en) begin
      res <= res_d;
      if (ctl.cw.sq_wr) begin
        sq <= prod;
      end
      if (ctl.cw.exp_shift) begin
        expo <= {1'b0, expo[FieldW-1:1]};
      end
    end
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the GF(2^8) arithmetic unit: directed table, then random items.
module tb_top;
  import gfau_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 24;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 125;
  localparam int NumPhases = 8;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct {
    bit    is_cfg;
    kind_t op;
    elem_t a;
    elem_t b;
    bit    pin;
    elem_t want;
  } vec_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] kind;
  logic [7:0] operand_a;
  logic [7:0] operand_b;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  elem_t    poly_cur;
  elem_t    field_q [$];
  bit       pin_en;
  elem_t    pin_val;
  bit       hold_req;
  int       hold_left;
  int       mode_left;
  rx_mode_t rx_mode;
  int       errors;
  int       cycle_cnt;
  elem_t    want_r;
  vec_t     dir_tab [$];

  gf256_arithmetic_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Carry-less product, one bit of y per step from the top, reduced by x^8 + poly.
  function automatic elem_t field_mul(elem_t x, elem_t y, elem_t poly);
    elem_t acc;
    bit    hi;
    acc = '0;
    for (int i = FieldW - 1; i >= 0; i--) begin
      hi  = acc[FieldW-1];
      acc = {acc[FieldW-2:0], 1'b0};
      if (hi) acc ^= poly;
      if (y[i]) acc ^= x;
    end
    return acc;
  endfunction

  // Square-and-multiply; squarings past the top exponent bit do not touch the result.
  function automatic elem_t field_pow(elem_t base, elem_t e, elem_t poly);
    elem_t acc;
    elem_t sq;
    acc = FieldOne;
    sq  = base;
    for (int i = 0; i < FieldW; i++) begin
      if (e[i]) acc = field_mul(acc, sq, poly);
      sq = field_mul(sq, sq, poly);
    end
    return acc;
  endfunction

  function automatic elem_t field_result(kind_t op, elem_t a, elem_t b, elem_t poly);
    elem_t r;
    case (op)
      KIND_ADD: r = a ^ b;
      KIND_MUL: r = field_mul(a, b, poly);
      KIND_POW: r = field_pow(a, b, poly);
      default:  r = field_pow(a, InvExp, poly);
    endcase
    return r;
  endfunction

  function automatic vec_t mk_op(kind_t op, elem_t a, elem_t b, bit pin, elem_t want);
    vec_t v;
    v.is_cfg = 1'b0;
    v.op     = op;
    v.a      = a;
    v.b      = b;
    v.pin    = pin;
    v.want   = want;
    return v;
  endfunction

  function automatic vec_t mk_cfg(elem_t poly);
    vec_t v;
    v        = mk_op(KIND_ADD, poly, '0, 1'b0, '0);
    v.is_cfg = 1'b1;
    return v;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(vec_t v);
    dir_tab.insert(dir_tab.size(), v);
  endfunction

  // Operands lean on the extremes now and then.
  function automatic elem_t pick_elem();
    elem_t e;
    case ($urandom_range(0, 7))
      0:       e = 8'h00;
      1:       e = 8'hFF;
      2:       e = FieldOne;
      default: e = elem_t'($urandom);
    endcase
    return e;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    errors++;
  endtask

  // Offer one item at the falling edge and hold it until the block takes it.
  task automatic offer(kind_t op, elem_t a, elem_t b, bit pin, elem_t want);
    @(negedge clk);
    in_valid  = 1'b1;
    kind      = op;
    operand_a = a;
    operand_b = b;
    pin_en    = pin;
    pin_val   = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Idle the input with junk on the payload; n sets the length of the gap.
  task automatic input_gap(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  = 1'b0;
      kind      = 2'($urandom);
      operand_a = elem_t'($urandom);
      operand_b = elem_t'($urandom);
    end
  endtask

  task automatic drain_results();
    input_gap(1);
    while (field_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_poly(elem_t poly);
    drain_results();
    repeat (SettleCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = poly;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    poly_cur = poly;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = elem_t'($urandom);
  endtask

  task automatic run_phase(int phase, int n, bit bursty);
    int    burst_left;
    kind_t op;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      // One long hold-off at the receiver while items keep coming.
      if (phase == 1 && i == 10) hold_req = 1'b1;
      // One pause of the sender until every result is home.
      if (phase == 2 && i == n / 2) drain_results();
      op = kind_t'($urandom_range(0, 3));
      offer(op, pick_elem(), pick_elem(), 1'b0, '0);
      if (bursty) begin
        burst_left--;
        if (burst_left == 0) begin
          input_gap($urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL gf256_arithmetic_unit");
      $finish;
    end
  end

  // Receiver: random stall modes, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    mode_left = 0;
    rx_mode   = RX_FREE;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:  out_stall = 1'b0;
          RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:  out_stall = ~out_stall;
        endcase
      end
    end
  end

  // Record expectations at acceptance and check results in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        field_q.insert(field_q.size(), pin_en ? pin_val :
                       field_result(kind_t'(kind), operand_a, operand_b, poly_cur));
      end
      if (out_valid && !out_stall) begin
        if (field_q.size() == 0) begin
          report_mismatch($sformatf("result %02h with no item pending", result));
        end else begin
          want_r = field_q.pop_front();
          if (result !== want_r) begin
            report_mismatch($sformatf("result %02h, expected %02h", result, want_r));
          end
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = '0;
    operand_a = '0;
    operand_b = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    pin_en    = 1'b0;
    pin_val   = '0;
    hold_req  = 1'b0;
    errors    = 0;
    cycle_cnt = 0;
    poly_cur  = PolyReset;

    // Reset polynomial: identities, known AES pairs and the edge operands.
    add_row(mk_op(KIND_ADD, 8'h00, 8'h00, 1'b1, 8'h00));
    add_row(mk_op(KIND_ADD, 8'hFF, 8'hFF, 1'b1, 8'h00));
    add_row(mk_op(KIND_ADD, 8'hFF, 8'h00, 1'b1, 8'hFF));
    add_row(mk_op(KIND_ADD, 8'hA5, 8'h5A, 1'b1, 8'hFF));
    add_row(mk_op(KIND_MUL, 8'h00, 8'hFF, 1'b1, 8'h00));
    add_row(mk_op(KIND_MUL, 8'h01, 8'hFF, 1'b1, 8'hFF));
    add_row(mk_op(KIND_MUL, 8'hFF, 8'h01, 1'b1, 8'hFF));
    add_row(mk_op(KIND_MUL, 8'h53, 8'hCA, 1'b1, 8'h01));
    add_row(mk_op(KIND_MUL, 8'h02, 8'h87, 1'b1, 8'h15));
    add_row(mk_op(KIND_MUL, 8'hFF, 8'hFF, 1'b0, 8'h00));
    // A zero exponent gives one, even for a zero base.
    add_row(mk_op(KIND_POW, 8'h00, 8'h00, 1'b1, 8'h01));
    add_row(mk_op(KIND_POW, 8'hFF, 8'h00, 1'b1, 8'h01));
    add_row(mk_op(KIND_POW, 8'h00, 8'h01, 1'b1, 8'h00));
    add_row(mk_op(KIND_POW, 8'h02, 8'h01, 1'b1, 8'h02));
    add_row(mk_op(KIND_POW, 8'h03, 8'hFF, 1'b0, 8'h00));
    // Zero inverts to zero; operand_b must not matter for inverse.
    add_row(mk_op(KIND_INV, 8'h00, 8'hFF, 1'b1, 8'h00));
    add_row(mk_op(KIND_INV, 8'h01, 8'h00, 1'b1, 8'h01));
    add_row(mk_op(KIND_INV, 8'h53, 8'hFF, 1'b1, 8'hCA));
    add_row(mk_op(KIND_INV, 8'hCA, 8'h00, 1'b1, 8'h53));
    // Reducible polynomial zero: the product keeps only its low byte.
    add_row(mk_cfg(8'h00));
    add_row(mk_op(KIND_MUL, 8'h80, 8'h02, 1'b1, 8'h00));
    add_row(mk_op(KIND_MUL, 8'h0F, 8'h0F, 1'b1, 8'h55));
    add_row(mk_op(KIND_POW, 8'hFF, 8'hFF, 1'b0, 8'h00));
    add_row(mk_cfg(8'hFF));
    add_row(mk_op(KIND_MUL, 8'hFF, 8'hFF, 1'b0, 8'h00));
    add_row(mk_op(KIND_INV, 8'h02, 8'h00, 1'b0, 8'h00));
    add_row(mk_cfg(PolyReset));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_poly(dir_tab[i].a);
      end else begin
        offer(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].pin, dir_tab[i].want);
        if ($urandom_range(0, 3) == 0) input_gap($urandom_range(1, 3));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       write_poly(PolyReset);
        1:       write_poly(8'h00);
        2:       write_poly(8'hFF);
        3:       write_poly(8'h1D);
        default: write_poly(elem_t'($urandom));
      endcase
      run_phase(p, PhaseItems, p != 0);
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    if (errors == 0 && field_q.size() == 0) begin
      $display("PASS gf256_arithmetic_unit");
    end else begin
      $display("FAIL gf256_arithmetic_unit");
    end
    $finish;
  end

endmodule

/* gf256_arithmetic_unit.f */
design/gfau_pkg.sv
design/gfau_mul.sv
design/gfau_seq.sv
design/gfau_dp.sv
design/gf256_arithmetic_unit.sv
sim/tb_top.sv
